// ----- rtl/rhc_pkg.sv -----
package rhc_pkg;

	localparam int ChanW = 8;                 // one color channel
	localparam int HueW  = 16;                // hue, 0.16 of a turn
	localparam int SatW  = 8;
	localparam int DivW  = 11;                // 6*d is at most 1530
	localparam int DvdW  = 16;                // 255*d is at most 65025
	localparam int NumCells = HueW;           // one quotient bit per cell

	// Work carried from cell to cell along the divider row.
	typedef struct packed {
		logic [DivW-1:0]  hrem;   // hue partial remainder, below hdiv
		logic [DivW-1:0]  hdiv;   // 6*d
		logic [HueW-1:0]  hq;     // hue quotient bits so far
		logic [ChanW-1:0] srem;   // saturation partial remainder, below sdiv
		logic [ChanW-1:0] sdiv;   // max
		logic [DvdW-1:0]  sdvd;   // 255*d, consumed MSB first
		logic [SatW-1:0]  sq;     // saturation quotient bits so far
		logic             grey;   // spread is zero: hue forced to zero
		logic             black;  // max is zero: saturation forced to zero
		logic [ChanW-1:0] value;  // max, passed through
	} cell_t;

endpackage

// ----- rtl/rhc_prep.sv -----
module rhc_prep (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [rhc_pkg::ChanW-1:0] red,
	input  logic [rhc_pkg::ChanW-1:0] green,
	input  logic [rhc_pkg::ChanW-1:0] blue,
	output logic                    out_valid,
	input  logic                    out_ready,
	output rhc_pkg::cell_t          out_data
);
	import rhc_pkg::*;

	localparam int NumW = DivW + 1;   // signed hue numerator before wrap

	logic [ChanW-1:0] mx, mn, d;
	logic [DivW-1:0]  d6;
	logic [NumW-1:0]  base, pos, neg, num;
	cell_t            nxt;
	logic             valid_q;

	always_comb begin
		mx = (red > green) ? red : green;
		mx = (mx > blue) ? mx : blue;
		mn = (red < green) ? red : green;
		mn = (mn < blue) ? mn : blue;
		d  = mx - mn;
		d6 = ({{(DivW-ChanW){1'b0}}, d} << 2) + ({{(DivW-ChanW){1'b0}}, d} << 1);

		// ties go to red, then green
		priority if (mx == red) begin
			base = '0;
			pos  = {{(NumW-ChanW){1'b0}}, green};
			neg  = {{(NumW-ChanW){1'b0}}, blue};
		end else if (mx == green) begin
			base = {{(NumW-ChanW){1'b0}}, d} << 1;
			pos  = {{(NumW-ChanW){1'b0}}, blue};
			neg  = {{(NumW-ChanW){1'b0}}, red};
		end else begin
			base = {{(NumW-ChanW){1'b0}}, d} << 2;
			pos  = {{(NumW-ChanW){1'b0}}, red};
			neg  = {{(NumW-ChanW){1'b0}}, green};
		end
		num = base + pos - neg;
		if (num[NumW-1]) begin
			num = num + {1'b0, d6};   // wrap by one turn
		end

		nxt.hrem  = num[DivW-1:0];
		nxt.hdiv  = d6;
		nxt.hq    = '0;
		nxt.srem  = '0;
		nxt.sdiv  = mx;
		nxt.sdvd  = ({{(DvdW-ChanW){1'b0}}, d} << ChanW) - {{(DvdW-ChanW){1'b0}}, d};
		nxt.sq    = '0;
		nxt.grey  = (d == '0);
		nxt.black = (mx == '0);
		nxt.value = mx;
	end

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			out_data <= nxt;
		end
	end

endmodule

// ----- rtl/rhc_cell.sv -----
module rhc_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  rhc_pkg::cell_t in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output rhc_pkg::cell_t out_data
);
	import rhc_pkg::*;

	logic [DivW:0]  ht;
	logic [ChanW:0] st;
	logic           hbit, sbit;
	cell_t          nxt;
	logic           valid_q;

	// One restoring step for each divider.
	always_comb begin
		nxt  = in_data;
		ht   = {in_data.hrem, 1'b0};
		hbit = (ht >= {1'b0, in_data.hdiv});
		nxt.hrem = hbit ? DivW'(ht - {1'b0, in_data.hdiv}) : ht[DivW-1:0];
		nxt.hq   = {in_data.hq[HueW-2:0], hbit};

		st   = {in_data.srem, in_data.sdvd[DvdW-1]};
		sbit = (st >= {1'b0, in_data.sdiv});
		nxt.srem = sbit ? ChanW'(st - {1'b0, in_data.sdiv}) : st[ChanW-1:0];
		nxt.sq   = {in_data.sq[SatW-2:0], sbit};
		nxt.sdvd = {in_data.sdvd[DvdW-2:0], 1'b0};
	end

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			out_data <= nxt;
		end
	end

endmodule

// ----- rtl/rgb_to_hsv_convert.sv -----
// channel | dir | fields in tdata, lowest bit up
// --------+-----+---------------------------------------------------------
// s_*     | in  | red_in [7:0], green_in [15:8], blue_in [23:16]
// m_*     | out | hue_out [15:0], sat_out [23:16], value_out [31:24]
//
// One request accepted per cycle while s_tready is high, one result per request, in order.
// The pipeline is a setup stage (max, min, numerators) and a row of
// 16 divider cells, each producing one hue and one saturation quotient bit.
// Every stage has its own valid bit; a stage moves when it is empty or the
// next one moves, so bubbles are squeezed out while the output is stalled.
// s_tready falls only when all 17 stages hold requests and m_tready is low.
// Reset clears the valid bits only; the data registers are not reset.
module rgb_to_hsv_convert (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // red_in, green_in, blue_in
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // hue_out, sat_out, value_out
);
	import rhc_pkg::*;

	logic  [NumCells:0] vld;
	logic  [NumCells:0] rdy;
	cell_t              dat [NumCells+1];
	cell_t              fin;

	// setup stage
	rhc_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.red       (s_tdata[ChanW-1:0]),
		.green     (s_tdata[2*ChanW-1:ChanW]),
		.blue      (s_tdata[3*ChanW-1:2*ChanW]),
		.out_valid (vld[0]),
		.out_ready (rdy[0]),
		.out_data  (dat[0])
	);

	// divider row: each cell hands its partial remainders to the next
	for (genvar i = 0; i < NumCells; i++) begin : g_cell
		rhc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (vld[i]),
			.in_ready  (rdy[i]),
			.in_data   (dat[i]),
			.out_valid (vld[i+1]),
			.out_ready (rdy[i+1]),
			.out_data  (dat[i+1])
		);
	end

	// last cell register is the output register
	assign fin      = dat[NumCells];
	assign m_tvalid = vld[NumCells];
	assign rdy[NumCells] = m_tready;
	assign m_tdata  = {fin.value,
	                   fin.black ? {SatW{1'b0}} : fin.sq,
	                   fin.grey  ? {HueW{1'b0}} : fin.hq};

	// zero saturation means a grey or black pixel, which has zero hue
	a_grey_hue: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[23:16] == 8'd0 |-> m_tdata[15:0] == 16'd0)
		else $error("nonzero hue with zero saturation");

	// black pixel carries zero saturation and hue
	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[31:24] == 8'd0 |-> m_tdata[23:0] == 24'd0)
		else $error("black pixel with nonzero hue or saturation");

	// input is refused only when the whole row is full and output stalled
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready && (&vld))
		else $error("request refused with room in the pipeline");

endmodule

// ----- tb/rgb_to_hsv_checker.sv -----
`timescale 1ns / 1ps

module rgb_to_hsv_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,   // red_in, green_in, blue_in
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,   // hue_out, sat_out, value_out
	output int          mismatch_cnt,
	output int          pending
);
	import rhc_pkg::*;

	// packed low field last, so hue lands in the low bits like m_tdata
	typedef struct packed {
		logic [ChanW-1:0] value;
		logic [SatW-1:0]  sat;
		logic [HueW-1:0]  hue;
	} hsv_t;

	hsv_t hsv_due[$];

	function automatic hsv_t rgb_to_hsv(input logic [ChanW-1:0] r, g, b);
		hsv_t res;
		int   mx;
		int   mn;
		int   spread;
		int   num;
		mx     = (r > g) ? int'(r) : int'(g);
		mx     = (mx > int'(b)) ? mx : int'(b);
		mn     = (r < g) ? int'(r) : int'(g);
		mn     = (mn < int'(b)) ? mn : int'(b);
		spread = mx - mn;
		res.value = mx[ChanW-1:0];
		res.sat   = (mx == 0) ? '0 : SatW'((255 * spread) / mx);
		res.hue   = '0;
		if (spread != 0) begin
			// dominant channel picks the sector; ties go red, then green
			if (mx == r)
				num = int'(g) - int'(b);
			else if (mx == g)
				num = 2 * spread + int'(b) - int'(r);
			else
				num = 4 * spread + int'(r) - int'(g);
			if (num < 0)
				num += 6 * spread;
			res.hue = HueW'((num * 65536) / (6 * spread));
		end
		return res;
	endfunction

	task automatic report(input string msg);
		mismatch_cnt++;
		$display("%0t ns: %s", $time, msg);
	endtask

	always @(posedge clk) begin
		hsv_t got;
		hsv_t want;
		if (!arst_n) begin
			mismatch_cnt = 0;
			hsv_due.delete();
		end else begin
			if (s_tvalid && s_tready)
				hsv_due.insert(hsv_due.size(),
					rgb_to_hsv(s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]));
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (hsv_due.size() == 0) begin
					report($sformatf("result %h with no request outstanding", m_tdata));
				end else begin
					want = hsv_due.pop_front();
					if (got.hue !== want.hue)
						report($sformatf("hue_out %0d, expected %0d", got.hue, want.hue));
					if (got.sat !== want.sat)
						report($sformatf("sat_out %0d, expected %0d", got.sat, want.sat));
					if (got.value !== want.value)
						report($sformatf("value_out %0d, expected %0d",
							got.value, want.value));
				end
			end
		end
		pending <= hsv_due.size();
	end

endmodule

// ----- tb/tb_rgb_to_hsv_convert.sv -----
`timescale 1ns / 1ps

module tb_rgb_to_hsv_convert;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;    // red_in, green_in, blue_in
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;    // hue_out, sat_out, value_out
	int          mismatch_cnt;
	int          pending;

	// per-cycle odds, in percent, of a sender gap and of a receiver stall
	int          gap_pct   = 0;
	int          stall_pct = 0;

	rgb_to_hsv_convert u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	rgb_to_hsv_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.mismatch_cnt (mismatch_cnt),
		.pending      (pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// receiver back-pressure, redrawn every cycle
	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= stall_pct);

	// Present one request, with random gaps ahead of it, and hold it until
	// the block takes it. Returns at the accepting edge.
	task automatic send_pixel(input logic [7:0] r, g, b);
		while ($urandom_range(99) < gap_pct) begin
			s_tvalid <= 1'b0;
			s_tdata  <= 24'($urandom);
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {b, g, r};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// Random pixel biased toward the interesting regions: near-grey pixels
	// (small spread, hue divider with tiny divisor), ties between channels,
	// channel extremes and one dominant channel over two dim ones. Plain random fills the rest.
	function automatic logic [23:0] random_pixel();
		logic [7:0] ch [3];
		int         base;
		int         pick;
		for (int i = 0; i < 3; i++)
			ch[i] = 8'($urandom);
		case ($urandom_range(9))
			5, 6: begin
				base = $urandom_range(251);
				for (int i = 0; i < 3; i++)
					ch[i] = 8'(base + $urandom_range(4));
			end
			7: begin
				// two equal channels, tie-break path
				pick = $urandom_range(2);
				ch[(pick + 1) % 3] = ch[pick];
			end
			8: begin
				for (int i = 0; i < 3; i++)
					case ($urandom_range(3))
						0: ch[i] = 8'd0;
						1: ch[i] = 8'd1;
						2: ch[i] = 8'd254;
						default: ch[i] = 8'd255;
					endcase
			end
			9: begin
				// one dominant channel over two dim ones
				pick = $urandom_range(2);
				ch[(pick + 1) % 3] = 8'($urandom_range(3));
				ch[(pick + 2) % 3] = 8'($urandom_range(3));
			end
			default: ;
		endcase
		return {ch[2], ch[1], ch[0]};
	endfunction

	// Watchdog, far beyond the slowest legal run (521 requests, each delayed
	// by random gap and stall cycles, then the drain of the pipeline).
	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		logic [23:0] px;
		int          gap_tbl   [4] = '{0, 72, 0, 11};
		int          stall_tbl [4] = '{0, 0, 72, 11};
		arst_n   = 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners, at full rate
		send_pixel(8'd0,   8'd0,   8'd0);     // black: no saturation
		send_pixel(8'd255, 8'd255, 8'd255);   // white: grey, full value
		send_pixel(8'd128, 8'd128, 8'd128);   // mid grey: hue forced to zero
		send_pixel(8'd1,   8'd1,   8'd1);
		send_pixel(8'd255, 8'd0,   8'd0);     // pure primaries
		send_pixel(8'd0,   8'd255, 8'd0);
		send_pixel(8'd0,   8'd0,   8'd255);
		send_pixel(8'd255, 8'd255, 8'd0);     // red/green tie goes to red
		send_pixel(8'd0,   8'd255, 8'd255);   // green/blue tie goes to green
		send_pixel(8'd255, 8'd0,   8'd255);   // red/blue tie, negative hue wraps
		send_pixel(8'd255, 8'd0,   8'd1);     // wrap just below a full turn
		send_pixel(8'd1,   8'd0,   8'd0);     // smallest spread, smallest max
		send_pixel(8'd0,   8'd1,   8'd0);
		send_pixel(8'd0,   8'd0,   8'd1);
		send_pixel(8'd255, 8'd254, 8'd254);   // spread one at full max
		send_pixel(8'd254, 8'd255, 8'd0);
		send_pixel(8'd0,   8'd254, 8'd255);
		send_pixel(8'd1,   8'd2,   8'd3);
		send_pixel(8'd200, 8'd100, 8'd50);
		send_pixel(8'd170, 8'd85,  8'd255);
		send_pixel(8'd85,  8'd170, 8'd0);

		// random requests, four handshake regimes in turn
		for (int ph = 0; ph < 4; ph++) begin
			gap_pct   = gap_tbl[ph];
			stall_pct = stall_tbl[ph];
			for (int n = 0; n < 125; n++) begin
				px = random_pixel();
				send_pixel(px[7:0], px[15:8], px[23:16]);
			end
		end
		s_tvalid <= 1'b0;
		stall_pct = 0;

		// drain, then a margin past the pipeline for stray results
		do
			@(posedge clk);
		while (pending != 0);
		repeat (40) @(posedge clk);

		if (mismatch_cnt == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ----- rgb_to_hsv_convert.f -----
rtl/rhc_pkg.sv
rtl/rhc_prep.sv
rtl/rhc_cell.sv
rtl/rgb_to_hsv_convert.sv
tb/rgb_to_hsv_checker.sv
tb/tb_rgb_to_hsv_convert.sv
